// ===== hw/rtl/dcs_pkg.sv =====
// Shared types, constants and helpers for the dedispersion channel summer.
// Used by dedispersion_channel_sum; depends on nothing else.
package dcs_pkg;

  // Default sizes of the stores.
  localparam int unsigned CHANNELS_DEF   = 512;
  localparam int unsigned DM_TRIALS_DEF  = 1024;
  localparam int unsigned TIME_DEPTH_DEF = 2048;

  // Fixed field widths.
  localparam int unsigned TIME_W   = 11;
  localparam int unsigned CHAN_W   = 9;
  localparam int unsigned DMI_W    = 10;
  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned DELAY_W  = 11;
  localparam int unsigned SUM_W    = 25;
  localparam int unsigned CCNT_W   = 10;
  localparam int unsigned DCNT_W   = 11;
  localparam int unsigned CFG_W    = 11;

  // An 11-bit value reduced by a time depth of at least 16 has a quotient
  // below 128, so seven conditional subtractions are enough.
  localparam int unsigned WRAP_STEPS = 7;
  localparam int unsigned TIME_MAX   = 2047;

  // Register reset values.
  localparam logic [CCNT_W-1:0] CHANNEL_COUNT_RST = 10'd512;
  localparam logic [DCNT_W-1:0] DM_COUNT_RST      = 11'd1024;

  // Saturation limits of the result.
  localparam logic signed [SUM_W-1:0] SUM_MAX = 25'sh0FFFFFF;
  localparam logic signed [SUM_W-1:0] SUM_MIN = 25'sh1000000;

  // Register indexes of the configuration port.
  typedef enum logic {
    REG_CHANNEL_COUNT = 1'b0,
    REG_DM_COUNT      = 1'b1
  } reg_idx_e;

  // Operation codes of an input transaction.
  typedef enum logic [1:0] {
    OP_WRITE_SAMPLE = 2'd0,
    OP_WRITE_DELAY  = 2'd1,
    OP_QUERY        = 2'd2
  } op_e;

  // Sequencer states.
  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_EXEC  = 5'b00010,
    S_RUN   = 5'b00100,
    S_DRAIN = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  // Reduces an 11-bit time value modulo the ring depth by restoring
  // subtraction of the depth shifted left by each possible quotient bit.
  function automatic logic [TIME_W-1:0] wrap_time(input logic [TIME_W-1:0] v,
                                                  input int unsigned depth);
    logic [TIME_W-1:0] r;
    int unsigned       step;
    r = v;
    for (int k = WRAP_STEPS - 1; k >= 0; k--) begin
      step = depth << k;
      if (step <= TIME_MAX && 32'(r) >= step) begin
        r = r - TIME_W'(step);
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/dedispersion_channel_sum.sv =====
// Top level of the brute-force incoherent dedispersion channel summer.
// Holds the ring sample store and the delay table; depends on dcs_pkg.
//
// Usage: one input channel (valid/stall) carries transactions that write a
// sample, write a channel delay for a trial measure, or query a sum. Only a
// query produces a result transaction on the output channel (valid/stall).
// Two configuration registers, channel_count and dm_count, must be written
// through a plain write port only while idle; the block does not enforce it.
// Flow: the block takes one transaction at a time; a write passes through
// the execute state and returns to idle. A query with a valid trial index
// makes one delay read and one sample read per channel, issued once per
// cycle through the single read port of each store, with a three-stage
// read, address and accumulate pipeline behind. A query with a bad trial
// index, or with no channels, skips the channel loop and goes to its result.
// A finished result sits in an output register; the next transaction is
// taken while it waits, but a following query holds in its last state until
// the register is free. Reset returns the registers to their defaults and
// empties the pipeline; the stores are not cleared and hold garbage until
// written.
module dedispersion_channel_sum #(
  parameter int unsigned CHANNELS   = dcs_pkg::CHANNELS_DEF,
  parameter int unsigned DM_TRIALS  = dcs_pkg::DM_TRIALS_DEF,
  parameter int unsigned TIME_DEPTH = dcs_pkg::TIME_DEPTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // Configuration port
  input  logic                                cfg_we_i,
  input  logic                                cfg_index_i,
  input  logic [dcs_pkg::CFG_W-1:0]           cfg_wdata_i,
  // Input channel
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [1:0]                          operation_i,
  input  logic [dcs_pkg::TIME_W-1:0]          time_index_i,
  input  logic [dcs_pkg::CHAN_W-1:0]          channel_i,
  input  logic [dcs_pkg::DMI_W-1:0]           dm_index_i,
  input  logic signed [dcs_pkg::SAMPLE_W-1:0] sample_value_i,
  input  logic [dcs_pkg::DELAY_W-1:0]         delay_value_i,
  // Output channel
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [dcs_pkg::SUM_W-1:0]    dm_sum_o,
  output logic                                status_o
);

  localparam int unsigned CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int unsigned DM_W   = (DM_TRIALS > 1) ? $clog2(DM_TRIALS) : 1;
  localparam int unsigned SLOT_W = $clog2(TIME_DEPTH);
  localparam int unsigned CNT_W  = $clog2(CHANNELS + 1);
  localparam int unsigned ACC_W  = (dcs_pkg::SAMPLE_W + 1 + CH_W > dcs_pkg::SUM_W) ?
                                   dcs_pkg::SAMPLE_W + 1 + CH_W : dcs_pkg::SUM_W;

  // Stores
  logic [dcs_pkg::SAMPLE_W-1:0] sample_mem [TIME_DEPTH][CHANNELS];
  logic [dcs_pkg::DELAY_W-1:0]  delay_mem  [DM_TRIALS][CHANNELS];

  // Control state
  dcs_pkg::state_e             state_q, state_d;
  logic [CNT_W-1:0]            cnt_q;
  logic                        v1_q, v2_q;
  logic                        out_valid_q;
  logic [dcs_pkg::CCNT_W-1:0]  channel_count_q;
  logic [dcs_pkg::DCNT_W-1:0]  dm_count_q;

  // Captured transaction and query working registers
  logic [1:0]                  op_q;
  logic [dcs_pkg::TIME_W-1:0]  time_q;
  logic [dcs_pkg::CHAN_W-1:0]  channel_q;
  logic [dcs_pkg::DMI_W-1:0]   dm_idx_q;
  logic [dcs_pkg::SAMPLE_W-1:0] sample_q;
  logic [dcs_pkg::DELAY_W-1:0] delay_q;
  logic [SLOT_W-1:0]           tm_q;
  logic [CNT_W-1:0]            nch_q;
  logic                        bad_q;
  logic [CH_W-1:0]             ch1_q;
  logic [dcs_pkg::DELAY_W-1:0] delay_rd_q;
  logic signed [dcs_pkg::SAMPLE_W-1:0] samp_rd_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic signed [dcs_pkg::SUM_W-1:0] dm_sum_q;
  logic                        status_q;

  // Combinational helpers
  logic                        in_accept;
  logic [dcs_pkg::TIME_W-1:0]  t_wrap;
  logic [dcs_pkg::DELAY_W-1:0] d_wrap;
  logic                        ch_ok, dm_wr_ok, bad_dm;
  logic [CNT_W-1:0]            nch_d;
  logic                        issue, last_issue, out_load;
  logic                        exec_sample, exec_delay;
  logic [SLOT_W:0]             slot_sum;
  logic [SLOT_W-1:0]           slot_rd;
  logic signed [ACC_W-1:0]     sum_max_ext, sum_min_ext;
  logic signed [dcs_pkg::SUM_W-1:0] sat_sum;

  assign in_accept  = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != dcs_pkg::S_IDLE);

  assign t_wrap   = dcs_pkg::wrap_time(time_q, TIME_DEPTH);
  assign d_wrap   = dcs_pkg::wrap_time(delay_q, TIME_DEPTH);
  assign ch_ok    = 32'(channel_q) < CHANNELS;
  assign dm_wr_ok = 32'(dm_idx_q) < DM_TRIALS;
  assign bad_dm   = (dcs_pkg::DCNT_W'(dm_idx_q) >= dm_count_q) ||
                    (32'(dm_idx_q) >= DM_TRIALS);
  assign nch_d    = (32'(channel_count_q) > CHANNELS) ? CNT_W'(CHANNELS)
                                                      : CNT_W'(channel_count_q);

  assign exec_sample = (state_q == dcs_pkg::S_EXEC) &&
                       (op_q == dcs_pkg::OP_WRITE_SAMPLE) && ch_ok;
  assign exec_delay  = (state_q == dcs_pkg::S_EXEC) &&
                       (op_q == dcs_pkg::OP_WRITE_DELAY) && ch_ok && dm_wr_ok;

  assign issue      = (state_q == dcs_pkg::S_RUN);
  assign last_issue = issue && (cnt_q == nch_q - 1'b1);
  assign out_load   = (state_q == dcs_pkg::S_DONE) && (!out_valid_q || !out_stall_i);

  // Stored delays are already reduced below the depth, so one compare and
  // subtract brings the start slot plus delay back into the ring.
  assign slot_sum = (SLOT_W + 1)'(tm_q) + (SLOT_W + 1)'(delay_rd_q);
  assign slot_rd  = (slot_sum >= (SLOT_W + 1)'(TIME_DEPTH)) ?
                    SLOT_W'(slot_sum - (SLOT_W + 1)'(TIME_DEPTH)) : SLOT_W'(slot_sum);

  assign sum_max_ext = ACC_W'(dcs_pkg::SUM_MAX);
  assign sum_min_ext = ACC_W'(dcs_pkg::SUM_MIN);

  always_comb begin
    if (acc_q > sum_max_ext) begin
      sat_sum = dcs_pkg::SUM_MAX;
    end else if (acc_q < sum_min_ext) begin
      sat_sum = dcs_pkg::SUM_MIN;
    end else begin
      sat_sum = acc_q[dcs_pkg::SUM_W-1:0];
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      dcs_pkg::S_IDLE: begin
        if (in_accept) state_d = dcs_pkg::S_EXEC;
      end
      dcs_pkg::S_EXEC: begin
        if (op_q == dcs_pkg::OP_QUERY) begin
          state_d = (bad_dm || nch_d == '0) ? dcs_pkg::S_DONE : dcs_pkg::S_RUN;
        end else begin
          state_d = dcs_pkg::S_IDLE;
        end
      end
      dcs_pkg::S_RUN: begin
        if (last_issue) state_d = dcs_pkg::S_DRAIN;
      end
      dcs_pkg::S_DRAIN: begin
        if (!v1_q && !v2_q) state_d = dcs_pkg::S_DONE;
      end
      dcs_pkg::S_DONE: begin
        if (out_load) state_d = dcs_pkg::S_IDLE;
      end
      default: state_d = dcs_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q         <= dcs_pkg::S_IDLE;
      cnt_q           <= '0;
      v1_q            <= 1'b0;
      v2_q            <= 1'b0;
      out_valid_q     <= 1'b0;
      channel_count_q <= dcs_pkg::CHANNEL_COUNT_RST;
      dm_count_q      <= dcs_pkg::DM_COUNT_RST;
    end else begin
      state_q <= state_d;
      v1_q    <= issue;
      v2_q    <= v1_q;
      if (state_q == dcs_pkg::S_EXEC) begin
        cnt_q <= '0;
      end else if (issue) begin
        cnt_q <= cnt_q + 1'b1;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        case (cfg_index_i)
          dcs_pkg::REG_CHANNEL_COUNT: channel_count_q <= cfg_wdata_i[dcs_pkg::CCNT_W-1:0];
          dcs_pkg::REG_DM_COUNT:      dm_count_q      <= cfg_wdata_i[dcs_pkg::DCNT_W-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q      <= operation_i;
      time_q    <= time_index_i;
      channel_q <= channel_i;
      dm_idx_q  <= dm_index_i;
      sample_q  <= sample_value_i;
      delay_q   <= delay_value_i;
    end
    if (state_q == dcs_pkg::S_EXEC) begin
      tm_q  <= SLOT_W'(t_wrap);
      nch_q <= nch_d;
      bad_q <= bad_dm;
      acc_q <= '0;
    end else if (v2_q) begin
      acc_q <= acc_q + ACC_W'(samp_rd_q);
    end
    ch1_q <= cnt_q[CH_W-1:0];
    if (out_load) begin
      dm_sum_q <= bad_q ? '0 : sat_sum;
      status_q <= bad_q;
    end
  end

  // Delay table: written by delay transactions, read once per issued channel.
  always_ff @(posedge clk_i) begin
    if (exec_delay) begin
      delay_mem[DM_W'(dm_idx_q)][CH_W'(channel_q)] <= d_wrap;
    end
    if (issue) begin
      delay_rd_q <= delay_mem[DM_W'(dm_idx_q)][cnt_q[CH_W-1:0]];
    end
  end

  // Sample ring: written by sample transactions, read one stage after the delay.
  always_ff @(posedge clk_i) begin
    if (exec_sample) begin
      sample_mem[SLOT_W'(t_wrap)][CH_W'(channel_q)] <= sample_q;
    end
    if (v1_q) begin
      samp_rd_q <= sample_mem[slot_rd][ch1_q];
    end
  end

  assign out_valid_o = out_valid_q;
  assign dm_sum_o    = dm_sum_q;
  assign status_o    = status_q;

`ifndef SYNTHESIS
  // A sample reaches the accumulator only after its delay read was issued.
  assert property (@(posedge clk_i) disable iff (!rst_ni) v2_q |-> $past(v1_q))
    else $error("accumulate stage active without a preceding delay read");

  // The channel counter never runs past the channels of the current query.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (state_q == dcs_pkg::S_RUN) |-> (cnt_q < nch_q))
    else $error("channel counter beyond channel count");

  // A new transaction is only taken once the read pipeline is empty.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   in_accept |-> (!v1_q && !v2_q))
    else $error("transaction accepted while a query is still in flight");

  // A rejected trial index always reports a zero sum.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
                   (out_valid_o && status_o) |-> (dm_sum_o == '0))
    else $error("bad trial index with a non-zero sum");
`endif

endmodule
